// File: src/wsfhp_pkg.sv
// ----------------------------------------------------------------------------
// wsfhp_pkg
// Shared types and constants for the frame header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfhp_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned OPCODE_W = 4;
	localparam int unsigned LEN_W    = 64;
	localparam int unsigned LEN7_W   = 7;
	localparam int unsigned EXT_W    = 3;
	localparam int unsigned USER_W   = 1 + OPCODE_W;

	localparam int unsigned FIN_BIT = 7;
	localparam logic [LEN7_W-1:0] LEN_EXT16 = 7'd126;
	localparam logic [EXT_W-1:0]  EXT16_LAST = 3'd1;
	localparam logic [EXT_W-1:0]  EXT64_LAST = 3'd7;

	typedef enum logic [1:0] {
		PH_HEAD    = 2'd0,
		PH_LEN     = 2'd1,
		PH_EXT     = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} beat_t;

endpackage : wsfhp_pkg

`default_nettype wire

// File: src/websocket_frame_header_parser_top.sv
// ----------------------------------------------------------------------------
// websocket_frame_header_parser_top
// Tracks frame headers on a received byte stream, one result per byte.
//
//   channel   dir  tdata                    tlast        tuser
//   s_axis    in   [7:0] rx byte            -            -
//   m_axis    out  [63:0] payload length    frame done   [0] fin, [4:1] opcode
//
// One byte per cycle sustained while m_axis is not stalled; each result passes
// the input register, then the result register, before it reaches m_axis.
// arst_n clears the phase and all frame state.
// A stall on m_axis holds the result register; the input register then
// holds one more byte before s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_header_parser_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [63:0] payload_length
	output logic        m_axis_tlast,
	output logic [4:0]  m_axis_tuser    // [0] final_fragment, [4:1] frame_opcode
);
	import wsfhp_pkg::*;

	beat_t beat;
	logic  take;

	wsfhp_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.take          (take),
		.beat          (beat)
	);

	wsfhp_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.beat          (beat),
		.take          (take),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule : websocket_frame_header_parser_top

`default_nettype wire

// File: src/wsfhp_in_reg.sv
// ----------------------------------------------------------------------------
// wsfhp_in_reg
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfhp_in_reg (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire [wsfhp_pkg::BYTE_W-1:0] s_axis_tdata,
	input  wire                         take,
	output wsfhp_pkg::beat_t            beat
);
	import wsfhp_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;

	assign s_axis_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
		end
	end

	assign beat.valid = valid_s1;
	assign beat.data  = data_s1;

endmodule : wsfhp_in_reg

`default_nettype wire

// File: src/wsfhp_core.sv
// ----------------------------------------------------------------------------
// wsfhp_core
// Frame state tracker and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfhp_core (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wsfhp_pkg::beat_t            beat,
	output logic                        take,
	output logic                        m_axis_tvalid,
	input  wire                         m_axis_tready,
	output logic [wsfhp_pkg::LEN_W-1:0] m_axis_tdata,
	output logic                        m_axis_tlast,
	output logic [wsfhp_pkg::USER_W-1:0] m_axis_tuser
);
	import wsfhp_pkg::*;

	phase_t              phase_q, phase_d;
	logic                fin_q, fin_d;
	logic [OPCODE_W-1:0] opcode_q, opcode_d;
	logic                long_q, long_d;
	logic [EXT_W-1:0]    ext_q, ext_d;
	logic [LEN_W-1:0]    len_q, len_d;
	logic [LEN_W-1:0]    rcvd_q, rcvd_d;
	logic                done_d;

	logic [LEN7_W-1:0] code;
	logic [LEN_W-1:0]  len_shift;
	logic [LEN_W-1:0]  rcvd_inc;
	logic              ext_last;
	logic              step;

	logic                valid_s2;
	logic                last_s2;
	logic [USER_W-1:0]   user_s2;
	logic [LEN_W-1:0]    len_s2;

	assign take = !valid_s2 || m_axis_tready;
	assign step = take && beat.valid;

	assign code      = beat.data[LEN7_W-1:0];
	assign len_shift = {len_q[LEN_W-BYTE_W-1:0], beat.data};
	assign rcvd_inc  = rcvd_q + LEN_W'(1);
	assign ext_last  = long_q ? (ext_q == EXT64_LAST) : (ext_q == EXT16_LAST);

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HEAD: phase_d = PH_LEN;
			PH_LEN: begin
				if (code < LEN_EXT16) begin
					phase_d = (code == '0) ? PH_HEAD : PH_PAYLOAD;
				end else begin
					phase_d = PH_EXT;
				end
			end
			PH_EXT: begin
				if (ext_last) begin
					phase_d = (len_shift == '0) ? PH_HEAD : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (rcvd_inc >= len_q) begin
					phase_d = PH_HEAD;
				end
			end
			default: phase_d = PH_HEAD;
		endcase
	end

	// frame fields and done flag
	always_comb begin
		fin_d    = fin_q;
		opcode_d = opcode_q;
		long_d   = long_q;
		ext_d    = ext_q;
		len_d    = len_q;
		rcvd_d   = rcvd_q;
		done_d   = 1'b0;
		unique case (phase_q)
			PH_HEAD: begin
				fin_d    = beat.data[FIN_BIT];
				opcode_d = beat.data[OPCODE_W-1:0];
			end
			PH_LEN: begin
				if (code < LEN_EXT16) begin
					len_d  = LEN_W'(code);
					long_d = 1'b0;
					rcvd_d = '0;
					done_d = (code == '0);
				end else begin
					long_d = (code != LEN_EXT16);
					ext_d  = '0;
					len_d  = '0;
				end
			end
			PH_EXT: begin
				len_d = len_shift;
				if (ext_last) begin
					ext_d  = '0;
					rcvd_d = '0;
					done_d = (len_shift == '0);
				end else begin
					ext_d = ext_q + EXT_W'(1);
				end
			end
			PH_PAYLOAD: begin
				rcvd_d = rcvd_inc;
				done_d = (rcvd_inc >= len_q);
			end
			default: done_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEAD;
			fin_q    <= 1'b0;
			opcode_q <= '0;
			long_q   <= 1'b0;
			ext_q    <= '0;
			len_q    <= '0;
			rcvd_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (step) begin
				phase_q  <= phase_d;
				fin_q    <= fin_d;
				opcode_q <= opcode_d;
				long_q   <= long_d;
				ext_q    <= ext_d;
				len_q    <= len_d;
				rcvd_q   <= rcvd_d;
			end
			if (take) begin
				valid_s2 <= beat.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			last_s2 <= done_d;
			user_s2 <= {opcode_d, fin_d};
			len_s2  <= len_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tlast  = last_s2;
	assign m_axis_tuser  = user_s2;
	assign m_axis_tdata  = len_s2;

endmodule : wsfhp_core

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for websocket_frame_header_parser_top. Streams received bytes
// into the parser, one per beat, and predicts the frame status for every
// byte: frame done, FIN, opcode and the decoded payload length. Each result
// beat is compared field by field against the oldest prediction. A directed
// opening covers zero-length frames in all three length forms, the mask bit,
// and extreme FIN/opcode bytes. Random frames follow, with short, 16-bit and
// 64-bit length forms, over several source idle and sink stall mixes. The run
// ends on a frame with an all-ones 64-bit length.
// ----------------------------------------------------------------------------

import wsfhp_pkg::*;

typedef struct packed {
	logic                done;
	logic                fin;
	logic [OPCODE_W-1:0] opcode;
	logic [LEN_W-1:0]    length;
} frame_status_t;

class frame_scoreboard;
	phase_t              phase;
	logic                fin;
	logic [OPCODE_W-1:0] opcode;
	logic                long_form;
	logic [EXT_W-1:0]    ext_pos;
	logic [LEN_W-1:0]    length;
	logic [LEN_W-1:0]    received;
	frame_status_t       status_q[$];
	int                  errors;

	function new();
		phase     = PH_HEAD;
		fin       = 1'b0;
		opcode    = '0;
		long_form = 1'b0;
		ext_pos   = '0;
		length    = '0;
		received  = '0;
		errors    = 0;
	endfunction

	function int pending();
		return status_q.size();
	endfunction

	function logic finish_header();
		received = '0;
		if (length == '0) begin
			phase = PH_HEAD;
			return 1'b1;
		end
		phase = PH_PAYLOAD;
		return 1'b0;
	endfunction

	function void note_byte(logic [BYTE_W-1:0] b);
		frame_status_t    s;
		logic [LEN7_W-1:0] code;
		logic [EXT_W-1:0]  last_pos;
		s.done = 1'b0;
		code = b[LEN7_W-1:0];
		case (phase)
			PH_HEAD: begin
				fin    = b[FIN_BIT];
				opcode = b[OPCODE_W-1:0];
				phase  = PH_LEN;
			end
			PH_LEN: begin
				if (code < LEN_EXT16) begin
					length    = LEN_W'(code);
					long_form = 1'b0;
					s.done    = finish_header();
				end else begin
					long_form = (code != LEN_EXT16);
					ext_pos   = '0;
					length    = '0;
					phase     = PH_EXT;
				end
			end
			PH_EXT: begin
				last_pos = long_form ? EXT64_LAST : EXT16_LAST;
				length   = {length[LEN_W-BYTE_W-1:0], b};
				if (ext_pos >= last_pos) begin
					ext_pos = '0;
					s.done  = finish_header();
				end else begin
					ext_pos = ext_pos + 1'b1;
				end
			end
			default: begin
				received = received + 1'b1;
				if (received >= length) begin
					s.done = 1'b1;
					phase  = PH_HEAD;
				end
			end
		endcase
		s.fin    = fin;
		s.opcode = opcode;
		s.length = length;
		status_q.push_back(s);
	endfunction

	function void check_result(logic done, logic fin_a, logic [OPCODE_W-1:0] op_a,
			logic [LEN_W-1:0] len_a);
		frame_status_t s;
		if (status_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: unexpected result beat done=%0b fin=%0b op=%h len=%h",
					$realtime, done, fin_a, op_a, len_a);
			return;
		end
		s = status_q.pop_front();
		if (s.done !== done || s.fin !== fin_a || s.opcode !== op_a || s.length !== len_a)
		begin
			errors++;
			if (errors <= 10)
				$display("%0t: exp d=%0b f=%0b op=%h len=%h got d=%0b f=%0b op=%h len=%h",
					$realtime, s.done, s.fin, s.opcode, s.length,
					done, fin_a, op_a, len_a);
		end
	endfunction
endclass

module tb;

	localparam int FORM_SHORT = 0;
	localparam int FORM_EXT16 = 1;
	localparam int FORM_EXT64 = 2;
	localparam int PHASE_BYTES = 460;
	localparam logic [LEN7_W-1:0] LEN_EXT64 = 7'd127;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [4:0]  m_axis_tuser;

	frame_scoreboard sb;
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int bytes_sent     = 0;

	websocket_frame_header_parser_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tlast, m_axis_tuser[0], m_axis_tuser[4:1], m_axis_tdata);
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	// header, length byte, extension bytes big-endian, then n_payload bytes
	task automatic send_frame(input logic [7:0] head, input logic mask, input int form,
			input logic [63:0] length, input int n_payload);
		int n_ext;
		n_ext = (form == FORM_EXT64) ? 8 : (form == FORM_EXT16) ? 2 : 0;
		send_byte(head);
		case (form)
			FORM_SHORT: send_byte({mask, length[6:0]});
			FORM_EXT16: send_byte({mask, LEN_EXT16});
			default:    send_byte({mask, LEN_EXT64});
		endcase
		for (int i = n_ext - 1; i >= 0; i--)
			send_byte(length[i*8 +: 8]);
		for (int i = 0; i < n_payload; i++)
			send_byte(8'($urandom));
	endtask

	task automatic send_random_frame();
		int          r;
		int          form;
		logic [63:0] length;
		r = $urandom_range(99);
		if (r < 55) begin
			form   = FORM_SHORT;
			length = 64'($urandom_range(0, 12));
		end else if (r < 68) begin
			form   = FORM_SHORT;
			length = 64'($urandom_range(0, 125));
		end else if (r < 84) begin
			form   = FORM_EXT16;
			length = ($urandom_range(9) == 0) ? 64'($urandom_range(0, 300))
				: 64'($urandom_range(0, 30));
		end else begin
			form   = FORM_EXT64;
			length = 64'($urandom_range(0, 30));
		end
		send_frame(8'($urandom), 1'($urandom), form, length, int'(length));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct);
		int target;
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		target = bytes_sent + PHASE_BYTES;
		while (bytes_sent < target)
			send_random_frame();
		drain();
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_frame(8'h00, 1'b0, FORM_SHORT, 64'd0, 0);
		send_frame(8'h8F, 1'b1, FORM_SHORT, 64'd1, 1);
		send_frame(8'h01, 1'b0, FORM_EXT16, 64'd0, 0);
		send_frame(8'hFF, 1'b1, FORM_EXT64, 64'd0, 0);
		send_frame(8'h09, 1'b1, FORM_EXT16, 64'd2, 2);
		drain();

		run_phase(0, 0);
		run_phase(47, 0);
		run_phase(0, 47);
		run_phase(26, 26);

		send_frame(8'h7A, 1'b1, FORM_EXT64, '1, 5);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
